// ----- rtl/lrsgd_pkg.sv -----
package lrsgd_pkg;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int ACC_W  = 48;
  localparam int PRED_W = 17;

  localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
  localparam logic [15:0]        LR_RESET = 16'd655;
  localparam logic [16:0]        LABEL_MAX = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOOK,
    ST_TAB,
    ST_RATE,
    ST_HOLD,
    ST_DMUL,
    ST_UPD
  } st_t;

  typedef enum logic [1:0] {
    MS_FEAT,
    MS_RATE,
    MS_DELTA
  } mul_sel_t;

  // sequencer -> datapath
  typedef struct packed {
    logic     idle;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     lrerr_en;
    logic     upd_en;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic last_item;
    logic out_free;
    logic last_w;
  } stat_t;

endpackage

// ----- rtl/logistic_regression_sgd_update.sv -----
// A word that does not end a sample is accepted, then accumulated (ST_ACC).
// An ending word is also accumulated, then runs the lookup (ST_LOOK, ST_TAB),
// the rate multiply (ST_RATE, ST_HOLD) and, per weight, a delta multiply and an
// output register update (ST_DMUL, ST_UPD, waiting on out_stall); input frees after.
// Throughput is set by the single shared 36x17 multiplier and its sequencer.
// Reset: rst_n synchronous active low; weights 1.0, rate 655, no clearing pass.
module logistic_regression_sgd_update #(
  parameter int FEATURES            = 3,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: learning rate, unsigned Q0.16
  input  logic               cfg_wr_en,
  input  logic        [15:0] cfg_wr_data,
  // feature words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_feature_value,
  input  logic        [16:0] in_sample_label,
  input  logic               in_end_of_sample,
  input  logic               in_restart_fit,
  // updated weight words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_weight_value,
  output logic        [2:0]  out_weight_index,
  output logic               out_weight_saturated,
  output logic               out_last_weight
);
  import lrsgd_pkg::*;

  localparam int IW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int CW = $clog2(FEATURES + 1);

  ctrl_t ctl;
  stat_t stat;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic        [15:0]      lr_r;
  logic signed [31:0]      w_r   [FEATURES];
  logic signed [15:0]      row_r [FEATURES];   // no reset: read only once written
  logic signed [ACC_W-1:0] acc_r;
  logic        [CW-1:0]    cnt_r;
  logic        [IW-1:0]    i_r;                // weight walk index
  logic                    take_r;             // accepted word was buffered
  logic                    last_r;             // accepted word ends the sample
  logic        [16:0]      label_r;            // already clipped to 1.0
  logic signed [34:0]      lrerr_r;            // rate * error
  logic                    out_valid_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;
  logic        [PRED_W-1:0]  pred_r;

  // ---------------------------------------------------------------------------
  // Accept side
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic [CW-1:0]    cnt_eff;
  logic             take;
  logic [IW-1:0]    cnt_idx;
  logic [IW-1:0]    rd_idx;
  logic signed [31:0] w_rd;
  logic signed [31:0] w_op;

  assign in_stall = !ctl.idle;
  assign in_acc   = in_valid && !in_stall;

  // restart drops the partial sample, so this word counts as feature 0
  assign cnt_eff = in_restart_fit ? '0 : cnt_r;
  assign take    = cnt_eff < CW'(FEATURES);
  assign cnt_idx = take ? cnt_eff[IW-1:0] : '0;

  // one weight read port: slot of the incoming feature, or the walk index
  assign rd_idx = (ctl.mul_sel == MS_FEAT) ? cnt_idx : i_r;
  assign w_rd   = w_r[rd_idx];
  assign w_op   = in_restart_fit ? ONE_Q16 : w_rd;

  // ---------------------------------------------------------------------------
  // Error and update arithmetic
  // ---------------------------------------------------------------------------
  logic signed [17:0] err;
  logic               f_in;
  logic signed [15:0] f_i;
  logic signed [MUL_P_W-1:0] prod_rnd;
  logic signed [28:0] delta;
  logic signed [33:0] w_sum;
  logic signed [31:0] w_new;
  logic               w_sat;
  logic               last_w;

  assign err = $signed({1'b0, label_r}) - $signed({1'b0, pred_r});

  // a feature that never arrived acts as zero: weight passes through
  assign f_in = CW'(i_r) < cnt_r;
  assign f_i  = f_in ? row_r[i_r] : 16'sd0;

  // Q13.40 -> Q16.16, round half up
  assign prod_rnd = prod_r + MUL_P_W'(64'sd8388608);
  assign delta    = prod_rnd[MUL_P_W-1:24];
  assign w_sum    = {{2{w_rd[31]}}, w_rd} + {{5{delta[28]}}, delta};

  always_comb begin
    w_sat = 1'b0;
    w_new = w_sum[31:0];
    if (w_sum[33:31] != 3'b000 && w_sum[33:31] != 3'b111) begin
      w_sat = 1'b1;
      w_new = w_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  assign last_w = i_r == IW'(FEATURES - 1);

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  //   MS_FEAT : feature * weight        (dot product term, Q24.24)
  //   MS_RATE : error * learning rate   (once per sample)
  //   MS_DELTA: (rate*error) * feature  (once per weight)
  // ---------------------------------------------------------------------------
  always_comb begin
    case (ctl.mul_sel)
      MS_FEAT: begin
        mul_a = {{(MUL_A_W-32){w_op[31]}}, w_op};
        mul_b = {in_feature_value[15], in_feature_value};
      end
      MS_RATE: begin
        mul_a = {{(MUL_A_W-18){err[17]}}, err};
        mul_b = {1'b0, lr_r};
      end
      default: begin
        mul_a = {{(MUL_A_W-35){lrerr_r[34]}}, lrerr_r};
        mul_b = {f_i[15], f_i};
      end
    endcase
  end

  lrsgd_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // free running: acc_r -> table index -> prediction, two register stages
  lrsgd_sig #(
    .DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_sig (
    .clk    (clk),
    .acc    (acc_r),
    .pred_r (pred_r)
  );

  assign stat.in_valid  = in_valid;
  assign stat.last_item = last_r;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.last_w    = last_w;

  lrsgd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // ---------------------------------------------------------------------------
  // Accumulator with saturation to signed 48 bits
  // ---------------------------------------------------------------------------
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_nxt;

  assign acc_sum = {acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r[ACC_W-1:0]};

  always_comb begin
    acc_nxt = acc_sum[ACC_W-1:0];
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
    end else if (cfg_wr_en) begin
      lr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FEATURES; k++) w_r[k] <= ONE_Q16;
    end else if (in_acc && in_restart_fit) begin
      for (int k = 0; k < FEATURES; k++) w_r[k] <= ONE_Q16;
    end else if (ctl.upd_en) begin
      w_r[i_r] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && take) begin
      row_r[cnt_idx] <= in_feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      i_r    <= '0;
      take_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (in_acc) begin
        take_r <= take;
        last_r <= in_end_of_sample;
        cnt_r  <= cnt_eff + CW'(take);
        if (in_restart_fit) begin
          acc_r <= '0;
        end
      end else if (ctl.acc_en && take_r) begin
        acc_r <= acc_nxt;
      end else if (ctl.upd_en && last_w) begin
        acc_r <= '0;
        cnt_r <= '0;
      end
      if (ctl.upd_en) begin
        i_r <= last_w ? '0 : i_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      label_r <= (in_sample_label > LABEL_MAX) ? LABEL_MAX : in_sample_label;
    end
    if (ctl.lrerr_en) begin
      lrerr_r <= prod_r[34:0];
    end
  end

  // output register: holds a word while the next one is being computed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.upd_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      out_weight_value     <= w_new;
      out_weight_index     <= 3'(i_r);
      out_weight_saturated <= w_sat;
      out_last_weight      <= last_w;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_short_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_end_of_sample) |-> ##2 !in_stall)
    else $error("non-ending word did not free the input after two cycles");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FEATURES))
    else $error("feature count beyond FEATURES");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_weight_saturated) |->
      (out_weight_value == 32'sh7FFF_FFFF || out_weight_value == 32'sh8000_0000))
    else $error("saturation flag on a weight that is not clipped");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_weight) |-> (out_weight_index == 3'(FEATURES - 1)))
    else $error("last weight flag on the wrong index");

  a_sample_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd_en && last_w) |=> (cnt_r == '0 && acc_r == '0 && !in_stall))
    else $error("sample state not cleared after the final weight");

endmodule

// ----- rtl/lrsgd_mul.sv -----
module lrsgd_mul (
  input  logic                                 clk,
  input  logic signed [lrsgd_pkg::MUL_A_W-1:0] a,
  input  logic signed [lrsgd_pkg::MUL_B_W-1:0] b,
  output logic signed [lrsgd_pkg::MUL_P_W-1:0] prod_r
);
  import lrsgd_pkg::*;

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(a) * MUL_P_W'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- rtl/lrsgd_sig.sv -----
module lrsgd_sig #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic signed [lrsgd_pkg::ACC_W-1:0]  acc,
  output logic        [lrsgd_pkg::PRED_W-1:0] pred_r
);
  import lrsgd_pkg::*;

  localparam int TW = $clog2(DEPTH);

  typedef logic [PRED_W-1:0] tab_t [DEPTH];

  // restoring divide, elaboration only
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // e^(-a) in Q30, a in Q16.16
  function automatic longint unsigned exp_neg_q30(longint unsigned a);
    longint unsigned r;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    r    = a << 10;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int k = 1; k <= 14; k++) begin
      term = udiv((term * r) >> 30, longint'(k));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    v = (sum < 0) ? 64'd0 : longint'(sum);
    for (int n = 0; n < 4; n++) begin
      v = (v * v + (64'd1 << 29)) >> 30;
    end
    return v;
  endfunction

  function automatic logic [PRED_W-1:0] sigmoid_of(longint x);
    longint unsigned a;
    longint unsigned den;
    longint unsigned pos;
    a   = (x < 0) ? longint'(-x) : longint'(x);
    den = (64'd1 << 30) + exp_neg_q30(a);
    pos = udiv((64'd1 << 46) + (den >> 1), den);
    if (x < 0) begin
      return PRED_W'(64'd65536 - pos);
    end
    return PRED_W'(pos);
  endfunction

  function automatic tab_t build_tab();
    tab_t   t;
    longint x;
    for (int i = 0; i < DEPTH; i++) begin
      x    = -longint'(524288) + ((longint'(2 * i + 1) <<< 19) / DEPTH);
      t[i] = sigmoid_of(x);
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  logic signed [39:0] z;
  logic signed [40:0] off;
  logic        [20:0] off_c;
  logic        [31:0] scaled;
  logic        [11:0] hi;
  logic      [TW-1:0] idx_nxt;
  logic      [TW-1:0] idx_r;

  // z = acc >> 8 (floor), window [-8, 8) mapped onto the table
  always_comb begin
    z   = acc[ACC_W-1:8];
    off = {z[39], z} + 41'sd524288;
    if (off[40]) begin
      off_c = '0;
    end else if (off > 41'sd1048576) begin
      off_c = 21'd1048576;
    end else begin
      off_c = off[20:0];
    end
    scaled = 32'(off_c) * 32'(DEPTH);
    hi     = scaled[31:20];
    if (hi > 12'(DEPTH - 1)) begin
      idx_nxt = TW'(DEPTH - 1);
    end else begin
      idx_nxt = hi[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pred_r <= SIG_TAB[idx_r];
  end

endmodule

// ----- rtl/lrsgd_ctrl.sv -----
module lrsgd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  lrsgd_pkg::stat_t stat,
  output lrsgd_pkg::ctrl_t ctl
);
  import lrsgd_pkg::*;

  st_t state_r;
  st_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (stat.in_valid) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = stat.last_item ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_nxt = ST_TAB;
      ST_TAB:  state_nxt = ST_RATE;
      ST_RATE: state_nxt = ST_HOLD;
      ST_HOLD: state_nxt = ST_DMUL;
      ST_DMUL: state_nxt = ST_UPD;
      ST_UPD: begin
        if (stat.out_free) begin
          state_nxt = stat.last_w ? ST_IDLE : ST_DMUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mul_sel  = MS_DELTA;
    case (state_r)
      ST_IDLE: begin
        ctl.idle    = 1'b1;
        ctl.mul_sel = MS_FEAT;
      end
      ST_ACC:  ctl.acc_en   = 1'b1;
      ST_RATE: ctl.mul_sel  = MS_RATE;
      ST_HOLD: ctl.lrerr_en = 1'b1;
      ST_UPD:  ctl.upd_en   = stat.out_free;
      default: ctl.mul_sel  = MS_DELTA;
    endcase
  end

endmodule

// ----- dv/tb_logistic_regression_sgd_update.sv -----
`timescale 1ns / 100ps

module tb_logistic_regression_sgd_update;
  import lrsgd_pkg::*;

  localparam int FEATURES      = 3;
  localparam int LUT_DEPTH     = 256;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 8;
  // an ending word frees the input only after its last weight is updated
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  localparam longint ACC_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO   = -ACC_HI - 1;
  localparam longint W_HI     = 64'sd2147483647;
  localparam longint W_LO     = -64'sd2147483648;
  localparam longint HALF_LSB = 64'sd8388608;  // 2^23, round half up before >>> 24
  localparam longint Q30_ONE  = 64'sd1073741824;

  // one updated weight as it leaves the block
  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         index;
    logic               saturated;
    logic               last;
  } weight_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic        [15:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_feature_value = '0;
  logic        [16:0] in_sample_label = '0;
  logic               in_end_of_sample = 1'b0;
  logic               in_restart_fit = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_weight_value;
  logic        [2:0]  out_weight_index;
  logic               out_weight_saturated;
  logic               out_last_weight;

  // trainer mirror: rate, weights, buffered row, dot product, sigmoid table
  logic        [15:0] rate_q16;
  logic signed [31:0] weight_mem [FEATURES];
  logic signed [15:0] row_mem [FEATURES];
  logic signed [47:0] dot_acc;
  int                 taken;
  logic        [16:0] sig_lut [LUT_DEPTH];

  weight_word_t expected_weights[$];

  int  errors;
  int  cycles;
  int  words_sent;
  int  samples_sent;
  int  restarts_sent;
  int  weights_seen;
  int  rates_used;
  int  next_gap = 1;
  int  out_hold;
  bit  calm;  // no idling on either side while set

  always #(CLK_PERIOD / 2) clk = ~clk;

  logistic_regression_sgd_update #(
    .FEATURES            (FEATURES),
    .SIGMOID_TABLE_DEPTH (LUT_DEPTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_feature_value     (in_feature_value),
    .in_sample_label      (in_sample_label),
    .in_end_of_sample     (in_end_of_sample),
    .in_restart_fit       (in_restart_fit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_weight_value     (out_weight_value),
    .out_weight_index     (out_weight_index),
    .out_weight_saturated (out_weight_saturated),
    .out_last_weight      (out_last_weight)
  );

  // ---------------------------------------------------------------------------
  // Sigmoid table: e^(-a) by a 14-term series of e^(-a/16) in Q30, squared
  // four times; entry i is sigmoid at the center of its slice of [-8, 8).
  // ---------------------------------------------------------------------------
  function automatic longint unsigned exp_neg_q30(input longint unsigned a);
    longint unsigned r;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    r    = a << 10;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * r) >> 30) / k;
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    v = (sum < 0) ? 0 : longint'(sum);
    for (int n = 0; n < 4; n++)
      v = (v * v + (64'd1 << 29)) >> 30;
    return v;
  endfunction

  function automatic logic [16:0] sigmoid_at(input longint x);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned pos;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    den = Q30_ONE + exp_neg_q30(mag);
    pos = ((64'd1 << 46) + (den >> 1)) / den;
    return (x < 0) ? 17'(65536 - pos) : 17'(pos);
  endfunction

  // dot product (Q24.24) -> z (Q16.16, floor) -> table slot, clamped
  function automatic logic [16:0] predict_from(input logic signed [47:0] acc);
    longint z;
    longint off;
    longint idx;
    z   = longint'(acc) >>> 8;
    off = z + 524288;
    if (off < 0)       off = 0;
    if (off > 1048576) off = 1048576;
    idx = (off * LUT_DEPTH) >>> 20;
    if (idx > LUT_DEPTH - 1) idx = LUT_DEPTH - 1;
    return sig_lut[idx];
  endfunction

  function automatic void trainer_reset();
    for (int i = 0; i < LUT_DEPTH; i++)
      sig_lut[i] = sigmoid_at(-524288 + longint'((longint'(2 * i + 1) << 19) / LUT_DEPTH));
    rate_q16 = LR_RESET;
    for (int i = 0; i < FEATURES; i++) begin
      weight_mem[i] = ONE_Q16;
      row_mem[i]    = '0;
    end
    dot_acc = '0;
    taken   = 0;
  endfunction

  // Takes one accepted feature word; on the ending word queues every updated weight.
  function automatic void learn_word(input logic signed [15:0] feat, input logic [16:0] label,
                                     input logic eos, input logic restart);
    longint       sum;
    longint       err;
    longint       f;
    longint       delta;
    longint       nw;
    logic [16:0]  lab;
    weight_word_t ww;
    if (restart) begin
      for (int i = 0; i < FEATURES; i++) weight_mem[i] = ONE_Q16;
      dot_acc = '0;
      taken   = 0;
    end
    // words past the FEATURES-th are dropped, but an ending one still ends
    if (taken < FEATURES) begin
      sum = longint'(dot_acc) + longint'(feat) * longint'(weight_mem[taken]);
      if (sum > ACC_HI) sum = ACC_HI;
      if (sum < ACC_LO) sum = ACC_LO;
      dot_acc        = sum[47:0];
      row_mem[taken] = feat;
      taken++;
    end
    if (eos) begin
      lab = (label > LABEL_MAX) ? LABEL_MAX : label;
      err = longint'(lab) - longint'(predict_from(dot_acc));
      for (int i = 0; i < FEATURES; i++) begin
        // missing features count as zero: weight passes through unchanged
        f     = (i < taken) ? longint'(row_mem[i]) : 0;
        delta = (longint'(rate_q16) * err * f + HALF_LSB) >>> 24;
        nw    = longint'(weight_mem[i]) + delta;
        ww.saturated = 1'b0;
        if (nw > W_HI) begin
          nw = W_HI;
          ww.saturated = 1'b1;
        end
        if (nw < W_LO) begin
          nw = W_LO;
          ww.saturated = 1'b1;
        end
        weight_mem[i] = nw[31:0];
        ww.value = nw[31:0];
        ww.index = 3'(i);
        ww.last  = (i == FEATURES - 1);
        expected_weights.push_back(ww);
      end
      dot_acc = '0;
      taken   = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------
  function automatic int pace();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic signed [15:0] rand_feature();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 1023) - 512);
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [16:0] rand_label();
    case ($urandom_range(0, 9))
      0, 1:    return 17'd0;
      2, 3:    return LABEL_MAX;
      4:       return 17'($urandom_range(65537, 131071));  // above 1.0
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Entered and left at a falling edge. Valid stays up into the next word
  // only when that word's gap is zero.
  task automatic send_word(input logic signed [15:0] feat, input logic [16:0] label,
                           input logic eos, input logic restart);
    if (next_gap > 0) repeat (next_gap) @(negedge clk);
    in_valid         = 1'b1;
    in_feature_value = feat;
    in_sample_label  = label;
    in_end_of_sample = eos;
    in_restart_fit   = restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    learn_word(feat, label, eos, restart);
    words_sent++;
    if (eos)     samples_sent++;
    if (restart) restarts_sent++;
    @(negedge clk);
    next_gap = pace();
    if (next_gap > 0) in_valid = 1'b0;
  endtask

  // input quiet, all weights back, then the tail of any dropped word
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_weights.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_rate(input logic [15:0] value);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    rate_q16  = value;
    rates_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall per word, compare against oldest expectation
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall = 1'b1;
      out_hold--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    weight_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      weights_seen++;
      if (expected_weights.size() == 0) begin
        flag_error($sformatf("unexpected weight word: value %0d idx %0d sat %0b last %0b",
                             out_weight_value, out_weight_index, out_weight_saturated,
                             out_last_weight));
      end else begin
        want = expected_weights.pop_front();
        if (out_weight_value !== want.value || out_weight_index !== want.index ||
            out_weight_saturated !== want.saturated || out_last_weight !== want.last) begin
          flag_error($sformatf({"weight word mismatch: expected value %0d idx %0d sat %0b ",
                                "last %0b, got value %0d idx %0d sat %0b last %0b"},
                               want.value, want.index, want.saturated, want.last,
                               out_weight_value, out_weight_index, out_weight_saturated,
                               out_last_weight));
        end
      end
      out_hold = pace();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d weight words outstanding",
               cycles, expected_weights.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // all-zero row: nothing moves, weights come back as the reset 1.0
  task automatic test_reset_weights();
    send_word(16'sd0, 17'd0, 1'b0, 1'b0);
    send_word(16'sd0, 17'd0, 1'b0, 1'b0);
    send_word(16'sd0, 17'd0, 1'b1, 1'b0);
  endtask

  // feature and label corners, including labels above 1.0 (clipped)
  task automatic test_field_extremes();
    send_word(-16'sd32768, 17'd0, 1'b0, 1'b0);
    send_word(16'sd32767,  17'd0, 1'b0, 1'b0);
    send_word(-16'sd1,     17'd0, 1'b1, 1'b0);
    send_word(16'sd1,      17'd0, 1'b0, 1'b0);
    send_word(16'sd0,      17'd0, 1'b0, 1'b0);
    send_word(-16'sd32768, 17'd65537, 1'b1, 1'b0);
    send_word(16'sd32767,  17'd0, 1'b0, 1'b0);
    send_word(16'sd32767,  17'd0, 1'b0, 1'b0);
    send_word(16'sd32767,  17'h1FFFF, 1'b1, 1'b0);
  endtask

  // fewer words than weights: the missing ones pass through unchanged
  task automatic test_short_samples();
    send_word(16'sd256, LABEL_MAX, 1'b1, 1'b0);
    send_word(-16'sd256, 17'd0, 1'b0, 1'b0);
    send_word(16'sd128, 17'd32768, 1'b1, 1'b0);
  endtask

  // extra words are dropped; an ending extra word still closes the sample
  task automatic test_long_samples();
    send_word(16'sd100,    17'd0, 1'b0, 1'b0);
    send_word(16'sd200,    17'd0, 1'b0, 1'b0);
    send_word(16'sd300,    17'd0, 1'b0, 1'b0);
    send_word(16'sd400,    17'd0, 1'b0, 1'b0);
    send_word(-16'sd32768, LABEL_MAX, 1'b1, 1'b0);
  endtask

  // restart mid-sample drops the partial row; restart on an ending word
  task automatic test_restart();
    send_word(16'sd500,  17'd0, 1'b0, 1'b0);
    send_word(16'sd600,  17'd0, 1'b0, 1'b1);
    send_word(16'sd700,  17'd0, 1'b0, 1'b0);
    send_word(-16'sd800, 17'd0, 1'b1, 1'b0);
    send_word(16'sd1000, LABEL_MAX, 1'b1, 1'b1);
  endtask

  // Mostly clean three-word samples with random content; the rest are short
  // or overlong rows, with the odd restart anywhere.
  task automatic train_random(input int words, input bit quiet);
    int first;
    int len;
    int kind;
    first = words_sent;
    calm  = quiet;
    while (words_sent - first < words) begin
      kind = $urandom_range(0, 99);
      if (kind < 75)      len = FEATURES;
      else if (kind < 87) len = $urandom_range(1, FEATURES - 1);
      else                len = $urandom_range(FEATURES + 1, FEATURES + 3);
      for (int j = 0; j < len; j++)
        send_word(rand_feature(), rand_label(), j == len - 1,
                  $urandom_range(0, 99) < 3);
    end
    calm = 1'b0;
  endtask

  // learning rate at both ends and in between, one training phase each
  task automatic test_rate_sweep();
    set_rate(16'hFFFF);
    train_random(90, 1'b0);
    set_rate(16'h0000);
    train_random(80, 1'b0);
    set_rate(16'h0001);
    train_random(60, 1'b1);
    set_rate(16'($urandom));
    train_random(110, 1'b0);
    set_rate(LR_RESET);
    train_random(90, 1'b0);
  endtask

  initial begin
    trainer_reset();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_reset_weights();
    test_field_extremes();
    test_short_samples();
    test_long_samples();
    test_restart();
    test_rate_sweep();

    wait_idle();

    $display("Covered %0d feature words in %0d samples (%0d with restart), %0d weight words",
             words_sent, samples_sent, restarts_sent, weights_seen);
    $display("Learning rate rewritten %0d times, %0d mismatches", rates_used, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- logistic_regression_sgd_update.f -----
rtl/lrsgd_pkg.sv
rtl/lrsgd_mul.sv
rtl/lrsgd_sig.sv
rtl/lrsgd_ctrl.sv
rtl/logistic_regression_sgd_update.sv
dv/tb_logistic_regression_sgd_update.sv
